>>> rtl/iis_pkg.sv
package iis_pkg;

  // field widths of one transaction
  localparam int unsigned WordW  = 32;
  localparam int unsigned PosW   = 8;
  localparam int unsigned CountW = 7;

  // default number of entries
  localparam int unsigned Depth = 64;

  // read value for a get outside the held entries
  localparam logic [WordW-1:0] MostNegative = {1'b1, {(WordW-1){1'b0}}};

  // operation codes
  typedef enum logic [1:0] {
    FUNC_PUSH = 2'd0,
    FUNC_POP  = 2'd1,
    FUNC_GET  = 2'd2,
    FUNC_PUT  = 2'd3
  } func_e;

  // per-cell control from the insert decoder
  typedef struct packed {
    logic load;   // take the inserted word
    logic shift;  // take the word of the cell below
  } cell_ctl_t;

endpackage

>>> rtl/iis_ifs.sv
// input channel: one operation per transaction
interface iis_in_if;
  logic                              valid;
  logic                              ready;
  logic [1:0]                        func;
  logic signed [iis_pkg::WordW-1:0]  value;
  logic signed [iis_pkg::PosW-1:0]   position;

  modport source (output valid, func, value, position, input ready);
  modport sink (input valid, func, value, position, output ready);
endinterface

// output channel: one result per transaction
interface iis_out_if;
  logic                              valid;
  logic                              ready;
  logic signed [iis_pkg::WordW-1:0]  read_value;
  logic                              ok;
  logic [iis_pkg::CountW-1:0]        count;

  modport source (output valid, read_value, ok, count, input ready);
  modport sink (input valid, read_value, ok, count, output ready);
endinterface

>>> rtl/iis_cell.sv
module iis_cell (
  input  logic                     clk_i,
  input  iis_pkg::cell_ctl_t       ctl_i,
  input  logic [iis_pkg::WordW-1:0] word_i,
  input  logic [iis_pkg::WordW-1:0] prev_i,
  output logic [iis_pkg::WordW-1:0] word_o
);

  logic [iis_pkg::WordW-1:0] word_q;

  // load the new word at the insert point, shift up above it
  always_ff @(posedge clk_i) begin
    if (ctl_i.load) begin
      word_q <= word_i;
    end else if (ctl_i.shift) begin
      word_q <= prev_i;
    end
  end

  assign word_o = word_q;

endmodule

>>> rtl/indexed_insert_stack.sv
// Stack of DEPTH signed 32-bit words held in a row of register cells, bottom
// at position 0. Operations are push, pop, get (read at a position) and put
// (insert at a position, entries at and above it move up by one; a position
// past the top appends). Every transaction yields one result: all cells
// shift in the same clock, and a get reads through one DEPTH-to-1
// multiplexer into the result register. A new transaction is taken each
// cycle while the result register is empty or being drained.
// Refused operations (pop when empty, push or put when full, put or get at a
// negative position, get at or above the top) leave the stack unchanged and
// return ok low; a refused get returns the most negative word. The count
// field reports the entries held after the operation, modulo 128.
module indexed_insert_stack #(
  parameter int unsigned DEPTH = iis_pkg::Depth
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  iis_in_if.sink     in_i,
  iis_out_if.source  out_o
);

  localparam int unsigned CntW = $clog2(DEPTH + 1);
  localparam int unsigned IdxW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CmpW = (CntW > iis_pkg::PosW - 1) ? CntW : iis_pkg::PosW - 1;

  logic [CntW-1:0]            cnt_q, cnt_d;
  logic                       out_valid_q;
  logic [iis_pkg::WordW-1:0]  rd_q, rd_d;
  logic                       ok_q, ok_d;
  logic [iis_pkg::CountW-1:0] cnt_out_q;

  logic                       in_acc;
  logic                       full, empty, pos_neg;
  logic [CmpW-1:0]            pos_ext, cnt_ext;
  logic                       ins_ok, pop_ok, get_ok;
  logic [CntW-1:0]            ins_pos;
  iis_pkg::func_e             func;

  logic [iis_pkg::WordW-1:0]  cell_word [DEPTH];
  iis_pkg::cell_ctl_t         cell_ctl [DEPTH];

  // handshake
  assign in_i.ready = !out_valid_q || out_o.ready;
  assign in_acc     = in_i.valid && in_i.ready;

  // operand decode
  assign func    = iis_pkg::func_e'(in_i.func);
  assign full    = (cnt_q == CntW'(DEPTH));
  assign empty   = (cnt_q == '0);
  assign pos_neg = in_i.position[iis_pkg::PosW-1];
  assign pos_ext = CmpW'(in_i.position[iis_pkg::PosW-2:0]);
  assign cnt_ext = CmpW'(cnt_q);

  always_comb begin
    ins_ok  = 1'b0;
    pop_ok  = 1'b0;
    get_ok  = 1'b0;
    ins_pos = cnt_q;
    case (func)
      iis_pkg::FUNC_PUSH: begin
        ins_ok = !full;
      end
      iis_pkg::FUNC_POP: begin
        pop_ok = !empty;
      end
      iis_pkg::FUNC_GET: begin
        get_ok = !pos_neg && (pos_ext < cnt_ext);
      end
      iis_pkg::FUNC_PUT: begin
        ins_ok = !pos_neg && !full;
        if (pos_ext < cnt_ext) begin
          ins_pos = pos_ext[CntW-1:0];
        end
      end
      default: begin
        ins_ok = 1'b0;
      end
    endcase
  end

  // cell row
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    assign cell_ctl[i].load  = in_acc && ins_ok && (ins_pos == CntW'(i));
    assign cell_ctl[i].shift = in_acc && ins_ok && (ins_pos < CntW'(i));

    if (i == 0) begin : g_bottom
      iis_cell u_cell (
        .clk_i  (clk_i),
        .ctl_i  (cell_ctl[i]),
        .word_i (in_i.value),
        .prev_i ('0),
        .word_o (cell_word[i])
      );
    end else begin : g_upper
      iis_cell u_cell (
        .clk_i  (clk_i),
        .ctl_i  (cell_ctl[i]),
        .word_i (in_i.value),
        .prev_i (cell_word[i-1]),
        .word_o (cell_word[i])
      );
    end
  end

  // next count and result
  always_comb begin
    cnt_d = cnt_q;
    if (in_acc && ins_ok) begin
      cnt_d = cnt_q + CntW'(1);
    end else if (in_acc && pop_ok) begin
      cnt_d = cnt_q - CntW'(1);
    end
    ok_d = ins_ok || pop_ok || get_ok;
    rd_d = '0;
    if (get_ok) begin
      rd_d = cell_word[pos_ext[IdxW-1:0]];
    end else if (func == iis_pkg::FUNC_GET) begin
      rd_d = iis_pkg::MostNegative;
    end
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      cnt_q <= cnt_d;
      if (in_acc) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // result register
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      rd_q      <= rd_d;
      ok_q      <= ok_d;
      cnt_out_q <= iis_pkg::CountW'(cnt_d);
    end
  end

  assign out_o.valid      = out_valid_q;
  assign out_o.read_value = rd_q;
  assign out_o.ok         = ok_q;
  assign out_o.count      = cnt_out_q;

  // checks
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntW'(DEPTH))
    else $error("entry count above depth");

  a_ins_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && ins_ok) |=> (cnt_q == $past(cnt_q) + CntW'(1)))
    else $error("insert did not grow the count");

  a_pop_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && pop_ok) |=> (cnt_q == $past(cnt_q) - CntW'(1)))
    else $error("pop did not shrink the count");

  a_idle_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_acc |=> $stable(cnt_q))
    else $error("count changed without a transaction");

  a_one_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && ins_ok && ins_pos < CntW'(DEPTH)) |-> (cell_ctl[0].load || cell_ctl[0].shift
      || ins_pos != '0))
    else $error("insert at bottom not loaded");

endmodule

>>> tb/indexed_insert_stack_tb.sv
`timescale 1ns / 100ps

module indexed_insert_stack_tb;

  localparam int unsigned StackDepth = iis_pkg::Depth;
  localparam int unsigned StallLimit = 1000;
  localparam int unsigned HoldCycles = 120;
  localparam int unsigned DrainCycles = 8;

  // one expected result of an operation
  typedef struct {
    logic signed [iis_pkg::WordW-1:0] read_value;
    logic                             ok;
    logic [iis_pkg::CountW-1:0]       count;
  } stack_result_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  iis_in_if  op_if ();
  iis_out_if res_if ();

  indexed_insert_stack #(
    .DEPTH(StackDepth)
  ) dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (op_if),
    .out_o (res_if)
  );

  always #10 clk_i = ~clk_i;

  // shadow copy of the stack
  logic signed [iis_pkg::WordW-1:0] shadow_words [StackDepth];
  int unsigned                      shadow_held = 0;
  stack_result_t                    pending_results [$];
  int unsigned                      mismatches = 0;

  // idle knobs for both sides
  int unsigned src_gap_max = 18;
  int unsigned sink_stall_max = 18;
  int unsigned hold_request = 0;

  // applies one operation to the shadow stack and returns its result
  function automatic stack_result_t apply_stack_op(iis_pkg::func_e op,
                                                   logic signed [iis_pkg::WordW-1:0] word,
                                                   logic signed [iis_pkg::PosW-1:0] pos);
    stack_result_t res;
    int            slot;
    int            i;
    res.read_value = '0;
    res.ok = 1'b0;
    case (op)
      iis_pkg::FUNC_PUSH: begin
        if (shadow_held < StackDepth) begin
          shadow_words[shadow_held] = word;
          shadow_held++;
          res.ok = 1'b1;
        end
      end
      iis_pkg::FUNC_POP: begin
        if (shadow_held > 0) begin
          shadow_held--;
          res.ok = 1'b1;
        end
      end
      iis_pkg::FUNC_GET: begin
        if (pos >= 0 && int'(pos) < int'(shadow_held)) begin
          res.read_value = shadow_words[int'(pos)];
          res.ok = 1'b1;
        end else begin
          res.read_value = iis_pkg::MostNegative;
        end
      end
      default: begin
        // insert: entries at and above the slot move up by one
        if (pos >= 0 && shadow_held < StackDepth) begin
          slot = (int'(pos) > int'(shadow_held)) ? int'(shadow_held) : int'(pos);
          for (i = int'(shadow_held); i > slot; i--) shadow_words[i] = shadow_words[i-1];
          shadow_words[slot] = word;
          shadow_held++;
          res.ok = 1'b1;
        end
      end
    endcase
    res.count = shadow_held[iis_pkg::CountW-1:0];
    return res;
  endfunction

  // offers one operation, entered and left just after a falling edge
  task automatic send_op(iis_pkg::func_e op, logic signed [iis_pkg::WordW-1:0] word,
                         logic signed [iis_pkg::PosW-1:0] pos);
    int unsigned gap;
    gap = $urandom_range(0, src_gap_max);
    if (gap > 0) begin
      op_if.valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    op_if.valid    <= 1'b1;
    op_if.func     <= op;
    op_if.value    <= word;
    op_if.position <= pos;
    @(posedge clk_i);
    while (!op_if.ready) @(posedge clk_i);
    pending_results.push_back(apply_stack_op(op, word, pos));
    @(negedge clk_i);
  endtask

  // position mostly near the held range, sometimes anywhere
  function automatic logic signed [iis_pkg::PosW-1:0] pick_position();
    int unsigned pick;
    pick = $urandom_range(0, 9);
    if (pick < 7) return iis_pkg::PosW'($urandom_range(0, shadow_held));
    if (pick < 9) return iis_pkg::PosW'($urandom_range(shadow_held, 127));
    return iis_pkg::PosW'($urandom);
  endfunction

  // receiver: random stalls, plus one long hold-off on request
  initial begin
    int unsigned stall;
    res_if.ready = 1'b0;
    @(posedge rst_ni);
    @(negedge clk_i);
    forever begin
      if (hold_request != 0) begin
        stall = hold_request;
        hold_request = 0;
      end else begin
        stall = $urandom_range(0, sink_stall_max);
      end
      if (stall > 0) begin
        res_if.ready <= 1'b0;
        repeat (stall) @(negedge clk_i);
      end
      res_if.ready <= 1'b1;
      @(posedge clk_i);
      while (!res_if.valid) @(posedge clk_i);
      @(negedge clk_i);
    end
  end

  // compare each result transaction with the oldest expectation
  always @(posedge clk_i) begin
    stack_result_t exp_res;
    if (rst_ni && res_if.valid && res_if.ready) begin
      if (pending_results.size() == 0) begin
        $error("unexpected result: read_value %0d ok %0b count %0d",
               res_if.read_value, res_if.ok, res_if.count);
        mismatches++;
      end else begin
        exp_res = pending_results.pop_front();
        if (res_if.read_value !== exp_res.read_value) begin
          $error("read_value: expected %0d, actual %0d", exp_res.read_value,
                 res_if.read_value);
          mismatches++;
        end
        if (res_if.ok !== exp_res.ok) begin
          $error("ok: expected %0b, actual %0b", exp_res.ok, res_if.ok);
          mismatches++;
        end
        if (res_if.count !== exp_res.count) begin
          $error("count: expected %0d, actual %0d", exp_res.count, res_if.count);
          mismatches++;
        end
      end
    end
  end

  // watchdog on cycles without any transaction
  int unsigned quiet_cycles = 0;
  always @(posedge clk_i) begin
    if ((op_if.valid && op_if.ready) || (res_if.valid && res_if.ready)) begin
      quiet_cycles <= 0;
    end else if (rst_ni) begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles + 1 >= StallLimit) begin
        $display("Regression FAIL");
        $finish;
      end
    end
  end

  // extremes, refusals on an empty stack, inserts at bottom, middle and past the top
  task automatic test_directed_cases();
    int i;
    send_op(iis_pkg::FUNC_POP, 32'sd0, 8'sd0);
    send_op(iis_pkg::FUNC_GET, 32'sd0, 8'sd0);
    send_op(iis_pkg::FUNC_GET, 32'sd0, -8'sd1);
    send_op(iis_pkg::FUNC_PUT, 32'sd7, -8'sd128);
    send_op(iis_pkg::FUNC_PUT, 32'h7fff_ffff, 8'sd127);
    send_op(iis_pkg::FUNC_PUSH, 32'h8000_0000, 8'sd0);
    send_op(iis_pkg::FUNC_PUSH, 32'sd0, 8'sd0);
    send_op(iis_pkg::FUNC_PUSH, 32'hffff_ffff, 8'sd0);
    send_op(iis_pkg::FUNC_PUT, 32'h1234_5678, 8'sd0);
    send_op(iis_pkg::FUNC_PUT, 32'ha5a5_a5a5, 8'sd2);
    for (i = 0; i <= 6; i++) send_op(iis_pkg::FUNC_GET, 32'sd0, iis_pkg::PosW'(i));
    send_op(iis_pkg::FUNC_GET, 32'sd0, 8'sd127);
    send_op(iis_pkg::FUNC_GET, 32'sd0, -8'sd128);
    send_op(iis_pkg::FUNC_POP, 32'sd0, 8'sd0);
    send_op(iis_pkg::FUNC_POP, 32'sd0, 8'sd0);
    send_op(iis_pkg::FUNC_GET, 32'sd0, 8'sd3);
    send_op(iis_pkg::FUNC_PUSH, 32'h5555_5555, 8'sd0);
  endtask

  // back to back: fill to the top, refusals when full, drain past empty
  task automatic test_fill_and_drain();
    src_gap_max = 0;
    sink_stall_max = 0;
    while (shadow_held < StackDepth) begin
      if ($urandom_range(0, 1) == 0) send_op(iis_pkg::FUNC_PUSH, $urandom, 8'sd0);
      else send_op(iis_pkg::FUNC_PUT, $urandom,
                   iis_pkg::PosW'($urandom_range(0, shadow_held + 1)));
    end
    send_op(iis_pkg::FUNC_PUSH, $urandom, 8'sd0);
    send_op(iis_pkg::FUNC_PUT, $urandom, 8'sd0);
    send_op(iis_pkg::FUNC_PUT, $urandom, 8'sd127);
    send_op(iis_pkg::FUNC_PUT, $urandom, -8'sd1);
    send_op(iis_pkg::FUNC_GET, 32'sd0, iis_pkg::PosW'(StackDepth - 1));
    send_op(iis_pkg::FUNC_GET, 32'sd0, iis_pkg::PosW'(StackDepth));
    send_op(iis_pkg::FUNC_GET, 32'sd0, 8'sd0);
    while (shadow_held > 0) send_op(iis_pkg::FUNC_POP, $urandom, iis_pkg::PosW'($urandom));
    send_op(iis_pkg::FUNC_POP, 32'sd0, 8'sd0);
  endtask

  // receiver holds off while the sender keeps offering
  task automatic test_output_backpressure();
    int i;
    src_gap_max = 0;
    sink_stall_max = 2;
    hold_request = HoldCycles;
    for (i = 0; i < 24; i++) begin
      if (i % 3 == 2) send_op(iis_pkg::FUNC_GET, 32'sd0, pick_position());
      else send_op(iis_pkg::FUNC_PUT, $urandom, pick_position());
    end
  endtask

  // random operations drifting between empty and full
  task automatic test_random_ops(int unsigned n_items);
    int unsigned    k;
    int unsigned    pick;
    bit             growing;
    iis_pkg::func_e op;
    growing = 1'b1;
    for (k = 0; k < n_items; k++) begin
      if (k % 100 == 0) begin
        case ((k / 100) % 4)
          0: begin src_gap_max = 18; sink_stall_max = 18; end
          1: begin src_gap_max = 0; sink_stall_max = 0; end
          2: begin src_gap_max = 0; sink_stall_max = 18; end
          default: begin src_gap_max = 18; sink_stall_max = 3; end
        endcase
      end
      if (shadow_held == 0) growing = 1'b1;
      else if (shadow_held == StackDepth) growing = 1'b0;
      else if ($urandom_range(0, 39) == 0) growing = !growing;
      pick = $urandom_range(0, 99);
      if (growing) begin
        if (pick < 35) op = iis_pkg::FUNC_PUSH;
        else if (pick < 65) op = iis_pkg::FUNC_PUT;
        else if (pick < 85) op = iis_pkg::FUNC_GET;
        else op = iis_pkg::FUNC_POP;
      end else begin
        if (pick < 50) op = iis_pkg::FUNC_POP;
        else if (pick < 75) op = iis_pkg::FUNC_GET;
        else if (pick < 85) op = iis_pkg::FUNC_PUSH;
        else op = iis_pkg::FUNC_PUT;
      end
      send_op(op, $urandom, pick_position());
    end
  endtask

  initial begin
    op_if.valid    = 1'b0;
    op_if.func     = iis_pkg::FUNC_PUSH;
    op_if.value    = '0;
    op_if.position = '0;
    repeat (3) @(negedge clk_i);
    rst_ni = 1'b1;

    test_directed_cases();
    test_fill_and_drain();
    test_output_backpressure();
    test_random_ops(720);

    op_if.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
